@@ rtl/ycrc_pkg.sv @@
// Shared types, protocol codes and the CRC-16 byte update for the YMODEM receiver.
`default_nettype none
package ycrc_pkg;

  localparam int ADDR_WIDTH_DEF = 24;
  localparam int OUT_ADDR_W     = 24;
  localparam int QDEPTH         = 4;
  localparam int QPTR_W         = $clog2(QDEPTH);

  localparam logic [7:0] B_SOH = 8'h01;
  localparam logic [7:0] B_STX = 8'h02;
  localparam logic [7:0] B_EOT = 8'h04;
  localparam logic [7:0] B_ACK = 8'h06;
  localparam logic [7:0] B_NAK = 8'h15;
  localparam logic [7:0] B_CAN = 8'h18;
  localparam logic [7:0] B_C   = 8'h43;

  localparam logic [23:0] MAX_BYTES_RST = 24'hFFFFFF;
  localparam logic [10:0] SIZE_SMALL    = 11'd128;
  localparam logic [10:0] SIZE_BIG      = 11'd1024;
  localparam logic [15:0] CRC_POLY      = 16'h1021;

  typedef enum logic [1:0] {
    K_REPLY  = 2'd0,
    K_WRITE  = 2'd1,
    K_DONE   = 2'd2,
    K_CANCEL = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_BLK   = 3'd1,
    PH_INV   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CRCH  = 3'd4,
    PH_CRCL  = 3'd5,
    PH_EOT2  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    FS_RUN    = 2'd0,
    FS_DONE   = 2'd1,
    FS_CANCEL = 2'd2
  } fin_t;

  typedef struct packed {
    kind_t                  kind;
    logic [7:0]             value;
    logic [OUT_ADDR_W-1:0]  address;
  } result_t;

  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/ycrc_front.sv @@
// Front end: block parser that turns each accepted word into at most two queued results.
`default_nettype none
module ycrc_front #(
  parameter int ADDR_WIDTH = ycrc_pkg::ADDR_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [23:0]      cfg_wdata,
  input  wire logic             acc,
  input  wire logic             action,
  input  wire logic [7:0]       rx_byte,
  output logic                  push,
  output ycrc_pkg::entry_t      ent
);
  import ycrc_pkg::*;

  localparam int SUM_W = ((ADDR_WIDTH > OUT_ADDR_W) ? ADDR_WIDTH : OUT_ADDR_W) + 1;

  logic [23:0]           max_bytes;
  phase_t                phase, phase_next;
  logic                  started, started_next;
  logic                  big_packet, big_packet_next;
  logic [7:0]            block_number, block_number_next;
  logic [10:0]           payload_count, payload_count_next;
  logic [15:0]           running_crc, running_crc_next;
  logic [7:0]            crc_high_byte, crc_high_byte_next;
  logic [7:0]            expected_block, expected_block_next;
  logic [ADDR_WIDTH-1:0] write_offset, write_offset_next;
  fin_t                  fin, fin_next;

  logic [SUM_W-1:0] wo_ext, max_ext, data_addr, room, size_ext, step, wo_sum;
  logic [10:0]      size11, cnt_inc;
  logic [8:0]       cmp_sum;

  always_comb begin
    size11   = big_packet ? SIZE_BIG : SIZE_SMALL;
    size_ext = SUM_W'(size11);
    wo_ext   = SUM_W'(write_offset);
    max_ext  = SUM_W'(max_bytes);
    data_addr = wo_ext + SUM_W'(payload_count);
    room     = max_ext - wo_ext;
    step     = (size_ext < room) ? size_ext : room;
    wo_sum   = wo_ext + step;
    cnt_inc  = payload_count + 11'd1;
    cmp_sum  = {1'b0, block_number} + {1'b0, rx_byte};
  end

  always_comb begin
    phase_next          = phase;
    started_next        = started;
    big_packet_next     = big_packet;
    block_number_next   = block_number;
    payload_count_next  = payload_count;
    running_crc_next    = running_crc;
    crc_high_byte_next  = crc_high_byte;
    expected_block_next = expected_block;
    write_offset_next   = write_offset;
    fin_next            = fin;
    push                = 1'b0;
    ent                 = '0;
    if (acc && fin == FS_RUN) begin
      if (action) begin
        if (!started) begin
          push = 1'b1;
          ent.r0 = '{kind: K_REPLY, value: B_C, address: '0};
        end
      end else begin
        started_next = 1'b1;
        case (phase)
          PH_START: begin
            if (rx_byte == B_SOH || rx_byte == B_STX) begin
              big_packet_next = (rx_byte == B_STX);
              phase_next = PH_BLK;
            end else if (rx_byte == B_EOT) begin
              push = 1'b1;
              ent.r0 = '{kind: K_REPLY, value: B_NAK, address: '0};
              phase_next = PH_EOT2;
            end else if (rx_byte == B_CAN) begin
              push = 1'b1;
              ent.r0 = '{kind: K_CANCEL, value: 8'h00, address: '0};
              fin_next = FS_CANCEL;
            end
          end
          PH_BLK: begin
            block_number_next = rx_byte;
            phase_next = PH_INV;
          end
          PH_INV: begin
            if (cmp_sum != 9'h0FF) begin
              push = 1'b1;
              ent.r0 = '{kind: K_REPLY, value: B_NAK, address: '0};
              phase_next = PH_START;
            end else begin
              payload_count_next = '0;
              running_crc_next = '0;
              phase_next = PH_DATA;
            end
          end
          PH_DATA: begin
            running_crc_next = crc_byte(running_crc, rx_byte);
            // header block payload is never stored
            if (block_number != 8'h00 && data_addr < max_ext) begin
              push = 1'b1;
              ent.r0 = '{kind: K_WRITE, value: rx_byte, address: data_addr[OUT_ADDR_W-1:0]};
            end
            payload_count_next = cnt_inc;
            if (cnt_inc >= size11) begin
              phase_next = PH_CRCH;
            end
          end
          PH_CRCH: begin
            crc_high_byte_next = rx_byte;
            phase_next = PH_CRCL;
          end
          PH_CRCL: begin
            phase_next = PH_START;
            push = 1'b1;
            if ({crc_high_byte, rx_byte} != running_crc) begin
              ent.r0 = '{kind: K_REPLY, value: B_NAK, address: '0};
            end else if (block_number == 8'h00) begin
              ent.two = 1'b1;
              ent.r0 = '{kind: K_REPLY, value: B_ACK, address: '0};
              ent.r1 = '{kind: K_REPLY, value: B_C, address: '0};
              expected_block_next = 8'h01;
            end else begin
              if (block_number == expected_block) begin
                if (wo_ext < max_ext) begin
                  write_offset_next = wo_sum[ADDR_WIDTH-1:0];
                end
                expected_block_next = expected_block + 8'h01;
              end
              ent.r0 = '{kind: K_REPLY, value: B_ACK, address: '0};
            end
          end
          PH_EOT2: begin
            phase_next = PH_START;
            if (rx_byte == B_EOT) begin
              push = 1'b1;
              ent.two = 1'b1;
              ent.r0 = '{kind: K_REPLY, value: B_ACK, address: '0};
              ent.r1 = '{kind: K_DONE, value: 8'h00, address: wo_ext[OUT_ADDR_W-1:0]};
              fin_next = FS_DONE;
            end
          end
          default: begin
            phase_next = PH_START;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes      <= MAX_BYTES_RST;
      phase          <= PH_START;
      started        <= 1'b0;
      big_packet     <= 1'b0;
      block_number   <= '0;
      payload_count  <= '0;
      running_crc    <= '0;
      crc_high_byte  <= '0;
      expected_block <= '0;
      write_offset   <= '0;
      fin            <= FS_RUN;
    end else begin
      if (cfg_we) begin
        max_bytes <= cfg_wdata;
      end
      phase          <= phase_next;
      started        <= started_next;
      big_packet     <= big_packet_next;
      block_number   <= block_number_next;
      payload_count  <= payload_count_next;
      running_crc    <= running_crc_next;
      crc_high_byte  <= crc_high_byte_next;
      expected_block <= expected_block_next;
      write_offset   <= write_offset_next;
      fin            <= fin_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/ycrc_queue.sv @@
// Short queue of result entries between the parser and the output stage.
`default_nettype none
module ycrc_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire ycrc_pkg::entry_t  wr_ent,
  input  wire logic              pop,
  output ycrc_pkg::entry_t       rd_ent,
  output ycrc_pkg::q_stat_t      stat
);
  import ycrc_pkg::*;

  localparam int CNT_W = $clog2(QDEPTH + 1);

  entry_t            slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;

  assign rd_ent     = slots[rd_ptr];
  assign stat.full  = (count == CNT_W'(QDEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/ycrc_back.sv @@
// Back end: output register that plays out one or two results per queue entry.
`default_nettype none
module ycrc_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ycrc_pkg::entry_t  q_ent,
  input  wire ycrc_pkg::q_stat_t q_stat,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ycrc_pkg::result_t      out_res,
  output logic                   out_last
);
  import ycrc_pkg::*;

  logic   cur_valid, cur_valid_next;
  entry_t cur, cur_next;
  logic   idx, idx_next;
  logic   load;

  assign out_valid = cur_valid;
  assign out_res   = idx ? cur.r1 : cur.r0;
  assign out_last  = idx || !cur.two;

  always_comb begin
    cur_valid_next = cur_valid;
    cur_next       = cur;
    idx_next       = idx;
    // refill when empty or when the final word of the entry leaves
    load = !cur_valid || (out_ready && out_last);
    pop  = load && !q_stat.empty;
    if (load) begin
      cur_valid_next = !q_stat.empty;
      cur_next       = q_ent;
      idx_next       = 1'b0;
    end else if (out_ready) begin
      idx_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 1'b0;
    end else begin
      cur_valid <= cur_valid_next;
      idx       <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
  end

endmodule
`default_nettype wire

@@ rtl/ymodem_crc_receiver_core.sv @@
// YMODEM CRC-16 receiver core: block parser, result queue and output stage.
//
// Slave stream: one word per UART event. tuser = 0 carries a received byte in
// tdata, tuser = 1 is a poll tick that answers 'C' until the first byte shows up.
// Master stream: results. tuser is the kind (reply, data write, done, cancelled),
// tdata[7:0] the reply or payload byte, tdata[31:8] the write address or the
// final byte count; tlast marks the last result caused by one input word.
// cfg_we/cfg_wdata load max_bytes, the destination capacity; write only when idle.
// Throughput: one input word per cycle while the queue is not full. Each word is
// parsed in the cycle it is accepted, and the CRC-16 update of a payload byte is
// done in that same cycle. The first result of a word is valid after the queue
// write and then the output register load. Words that cause two results (header
// ACK + 'C', final ACK + done) play both out from one queue entry; the four-entry
// queue absorbs these and any output stall, and s_axis_tready drops only when the
// queue is full.
// Reset clears the parser, empties the queue and sets max_bytes to 0xFFFFFF.
// After done or cancel every input word is taken and dropped until reset.
`default_nettype none
module ymodem_crc_receiver_core #(
  parameter int ADDR_WIDTH = ycrc_pkg::ADDR_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [23:0] cfg_wdata,     // max_bytes
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  input  wire logic        s_axis_tuser,  // [0] action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // [7:0] value, [31:8] address
  output logic [1:0]       m_axis_tuser,  // [1:0] kind
  output logic             m_axis_tlast
);
  import ycrc_pkg::*;

  logic    acc, push, pop;
  entry_t  push_ent, q_ent;
  q_stat_t q_stat;
  result_t res;

  assign s_axis_tready = !q_stat.full;
  assign acc = s_axis_tvalid && s_axis_tready;

  ycrc_front #(.ADDR_WIDTH(ADDR_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .action    (s_axis_tuser),
    .rx_byte   (s_axis_tdata),
    .push      (push),
    .ent       (push_ent)
  );

  ycrc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_ent (push_ent),
    .pop    (pop),
    .rd_ent (q_ent),
    .stat   (q_stat)
  );

  ycrc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_ent     (q_ent),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {res.address, res.value};
  assign m_axis_tuser = res.kind;

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == K_DONE || m_axis_tuser == K_CANCEL) |-> m_axis_tlast)
    else $error("done or cancel result not marked last");

  a_reply_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == K_REPLY |->
      (m_axis_tdata[7:0] == B_ACK || m_axis_tdata[7:0] == B_NAK || m_axis_tdata[7:0] == B_C))
    else $error("reply word carries an unknown code");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("output stage popped an empty queue");

  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == K_REPLY)
    else $error("non-final result of a word is not a reply");

endmodule
`default_nettype wire

@@ dv/ymodem_crc_checker.sv @@
// Checker for the YMODEM receiver core: predicts every result word and compares it.
module ymodem_crc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        m_tlast,
  output int          fail_count,
  output int          checked_count,
  output int          pending_count,
  output logic [23:0] offset_now
);
  timeunit 1ns;
  timeprecision 1ps;
  import ycrc_pkg::*;

  typedef struct {
    kind_t       kind;
    logic [7:0]  value;
    logic [23:0] address;
    logic        last;
  } outcome_t;

  outcome_t predicted[$];

  // receiver state as the protocol defines it
  logic [23:0] capacity;
  phase_t      phase;
  logic        started;
  logic        big;
  logic [7:0]  blk_num;
  logic [10:0] pcount;
  logic [15:0] crc;
  logic [7:0]  crc_hi;
  logic [7:0]  next_expected;
  logic [23:0] wofs;
  fin_t        fin;

  function automatic logic [15:0] crc16_fold(input logic [15:0] c_in, input logic [7:0] d);
    logic [15:0] c;
    c = c_in ^ {d, 8'h00};
    repeat (8) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic void emit(input kind_t k, input logic [7:0] v, input logic [23:0] a);
    outcome_t o;
    o.kind    = k;
    o.value   = v;
    o.address = a;
    o.last    = 1'b0;
    predicted.push_back(o);
  endfunction

  task automatic parse_rx_word(input logic act, input logic [7:0] b);
    int          n0;
    outcome_t    o;
    logic [31:0] wr_addr;
    logic [31:0] size;
    logic [31:0] room;
    n0 = predicted.size();
    if (fin != FS_RUN) return;
    size = big ? 32'd1024 : 32'd128;
    if (act) begin
      if (!started) emit(K_REPLY, B_C, 24'd0);
    end else begin
      started = 1'b1;
      case (phase)
        PH_START: begin
          if (b == B_SOH || b == B_STX) begin
            big   = (b == B_STX);
            phase = PH_BLK;
          end else if (b == B_EOT) begin
            emit(K_REPLY, B_NAK, 24'd0);
            phase = PH_EOT2;
          end else if (b == B_CAN) begin
            emit(K_CANCEL, 8'd0, 24'd0);
            fin = FS_CANCEL;
          end
        end
        PH_BLK: begin
          blk_num = b;
          phase   = PH_INV;
        end
        PH_INV: begin
          // 9-bit sum of number and complement must be exactly 0xFF
          if ({1'b0, blk_num} + {1'b0, b} != 9'h0FF) begin
            emit(K_REPLY, B_NAK, 24'd0);
            phase = PH_START;
          end else begin
            pcount = '0;
            crc    = '0;
            phase  = PH_DATA;
          end
        end
        PH_DATA: begin
          wr_addr = {8'd0, wofs} + {21'd0, pcount};
          crc     = crc16_fold(crc, b);
          // payload goes out before the verdict; the header block is never stored
          if (blk_num != 0 && wr_addr < {8'd0, capacity}) emit(K_WRITE, b, wr_addr[23:0]);
          pcount = pcount + 11'd1;
          if ({21'd0, pcount} >= size) phase = PH_CRCH;
        end
        PH_CRCH: begin
          crc_hi = b;
          phase  = PH_CRCL;
        end
        PH_CRCL: begin
          phase = PH_START;
          if ({crc_hi, b} != crc) begin
            emit(K_REPLY, B_NAK, 24'd0);
          end else if (blk_num == 0) begin
            emit(K_REPLY, B_ACK, 24'd0);
            emit(K_REPLY, B_C, 24'd0);
            next_expected = 8'd1;
          end else begin
            if (blk_num == next_expected) begin
              if (wofs < capacity) begin
                room = {8'd0, capacity} - {8'd0, wofs};
                wofs = wofs + ((size < room) ? size[23:0] : room[23:0]);
              end
              next_expected = next_expected + 8'd1;
            end
            emit(K_REPLY, B_ACK, 24'd0);
          end
        end
        PH_EOT2: begin
          phase = PH_START;
          if (b == B_EOT) begin
            emit(K_REPLY, B_ACK, 24'd0);
            emit(K_DONE, 8'd0, wofs);
            fin = FS_DONE;
          end
        end
        default: phase = PH_START;
      endcase
    end
    // flag the final result of this word
    if (predicted.size() > n0) begin
      o      = predicted.pop_back();
      o.last = 1'b1;
      predicted.push_back(o);
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      predicted.delete();
      capacity      = MAX_BYTES_RST;
      phase         = PH_START;
      started       = 1'b0;
      big           = 1'b0;
      blk_num       = '0;
      pcount        = '0;
      crc           = '0;
      crc_hi        = '0;
      next_expected = '0;
      wofs          = '0;
      fin           = FS_RUN;
    end else begin
      if (m_tvalid && m_tready) begin
        checked_count++;
        if (predicted.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: kind %0d value %02h address %06h last %0b",
                     m_tuser, m_tdata[7:0], m_tdata[31:8], m_tlast);
        end else begin
          want = predicted.pop_front();
          if (m_tuser !== want.kind || m_tdata[7:0] !== want.value ||
              m_tdata[31:8] !== want.address || m_tlast !== want.last) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result %0d: expected kind %0d value %02h address %06h last %0b",
                       checked_count, want.kind, want.value, want.address, want.last);
              $display("result %0d:      got kind %0d value %02h address %06h last %0b",
                       checked_count, m_tuser, m_tdata[7:0], m_tdata[31:8], m_tlast);
            end
          end
        end
      end
      if (cfg_we) capacity = cfg_wdata;
      if (s_tvalid && s_tready) parse_rx_word(s_tuser, s_tdata);
    end
    pending_count = predicted.size();
    offset_now    = wofs;
  end

endmodule

@@ dv/tb_ymodem_crc_receiver_core.sv @@
// Testbench top for the YMODEM receiver core: clock, reset, stimulus and verdict.
module tb_ymodem_crc_receiver_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ycrc_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE       = 8;
  localparam int ROUND_EVENTS = 10;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [23:0] cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int          fail_count;
  int          checked_count;
  int          pending_count;
  logic [23:0] offset_now;

  int          send_idle = 19;
  int          recv_idle = 62;
  int          cycle_count = 0;
  int          words_sent = 0;
  int          blocks_sent = 0;
  int          cap_writes = 0;
  logic [7:0]  next_blk = 8'd1;
  bit          by_cancel;

  ymodem_crc_receiver_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  ymodem_crc_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_tvalid      (s_axis_tvalid),
    .s_tready      (s_axis_tready),
    .s_tdata       (s_axis_tdata),
    .s_tuser       (s_axis_tuser),
    .m_tvalid      (m_axis_tvalid),
    .m_tready      (m_axis_tready),
    .m_tdata       (m_axis_tdata),
    .m_tuser       (m_axis_tuser),
    .m_tlast       (m_axis_tlast),
    .fail_count    (fail_count),
    .checked_count (checked_count),
    .pending_count (pending_count),
    .offset_now    (offset_now)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still outstanding",
               cycle_count, pending_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [15:0] frame_crc_step(input logic [15:0] c_in, input logic [7:0] d);
    logic [15:0] c;
    c = c_in ^ {d, 8'h00};
    repeat (8) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [7:0] pick_start();
    return ($urandom_range(1) == 0) ? B_STX : B_SOH;
  endfunction

  function automatic logic [23:0] pick_capacity();
    case ($urandom_range(4))
      0:       return 24'hFFFFFF;
      1:       return 24'd0;
      2:       return offset_now + 24'($urandom_range(300, 1));
      3:       return offset_now >> 1;
      default: return 24'($urandom);
    endcase
  endfunction

  // hold valid across back-to-back words; drop it only for idle cycles
  task automatic send_word(input logic act, input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= act;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [23:0] v);
    wait_idle();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_writes++;
  endtask

  task automatic send_block(input logic [7:0] start, input logic [7:0] num, input bit corrupt);
    logic [15:0] fcs;
    logic [7:0]  b;
    int          size;
    int          i;
    size = (start == B_STX) ? 1024 : 128;
    fcs  = '0;
    send_word(1'b0, start);
    send_word(1'b0, num);
    send_word(1'b0, ~num);
    for (i = 0; i < size; i++) begin
      b = 8'($urandom_range(255));
      // stray poll ticks mid-block must stay silent
      if ($urandom_range(49) == 0) send_word(1'b1, 8'($urandom_range(255)));
      send_word(1'b0, b);
      fcs = frame_crc_step(fcs, b);
    end
    if (corrupt) fcs = fcs ^ 16'($urandom_range(16'hFFFF, 1));
    send_word(1'b0, fcs[15:8]);
    send_word(1'b0, fcs[7:0]);
    blocks_sent++;
    if (!corrupt) begin
      if (num == 8'd0) next_blk = 8'd1;
      else if (num == next_blk) next_blk = next_blk + 8'd1;
    end
  endtask

  // one block of any flavor: good, bad CRC, duplicate, out of order or a repeated header
  task automatic send_any_block();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) send_block(B_SOH, next_blk, 1'b0);
    else if (roll < 60) send_block(B_SOH, next_blk, 1'b1);
    else if (roll < 75) send_block(B_SOH, next_blk - 8'd1, 1'b0);
    else if (roll < 90) send_block(B_SOH, next_blk + 8'($urandom_range(250, 2)), 1'b0);
    else send_block(B_SOH, 8'd0, 1'b0);
  endtask

  task automatic run_round(input int sidle, input int ridle, input bit with_block,
                           input bit any_block);
    int         roll;
    int         e;
    int         blk_at;
    int         k;
    logic [7:0] b;
    send_idle = sidle;
    recv_idle = ridle;
    blk_at    = $urandom_range(ROUND_EVENTS - 1);
    for (e = 0; e < ROUND_EVENTS; e++) begin
      if (with_block && e == blk_at) begin
        if (any_block) send_any_block();
        else send_block(B_SOH, next_blk, 1'b0);
      end
      roll = $urandom_range(99);
      if (roll < 30) begin
        // number and complement that do not add up to 0xFF
        b = 8'($urandom_range(255));
        send_word(1'b0, pick_start());
        send_word(1'b0, b);
        send_word(1'b0, ~b ^ 8'($urandom_range(255, 1)));
      end else if (roll < 50) begin
        // lone EOT: the byte after it is dropped
        do b = 8'($urandom_range(255)); while (b == B_EOT);
        send_word(1'b0, B_EOT);
        send_word(1'b0, b);
      end else if (roll < 70) begin
        do b = 8'($urandom_range(255));
        while (b == B_SOH || b == B_STX || b == B_EOT || b == B_CAN);
        send_word(1'b0, b);
      end else if (roll < 90) begin
        for (k = $urandom_range(3, 1); k > 0; k--) send_word(1'b1, 8'($urandom_range(255)));
      end else begin
        set_capacity(pick_capacity());
      end
    end
  endtask

  initial begin
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    set_capacity(24'hFFFFFF);

    // polls before the first byte answer 'C'; afterwards they are silent
    send_word(1'b1, 8'h00);
    send_word(1'b1, 8'hFF);
    send_word(1'b0, 8'h00);
    send_word(1'b1, 8'hA5);
    send_word(1'b0, 8'hFF);
    // complement checks, including a 9-bit sum of 0x100
    send_word(1'b0, B_SOH);
    send_word(1'b0, 8'h05);
    send_word(1'b0, 8'h05);
    send_word(1'b0, B_STX);
    send_word(1'b0, 8'hFF);
    send_word(1'b0, 8'h01);
    send_word(1'b0, B_SOH);
    send_word(1'b0, 8'h01);
    send_word(1'b0, 8'hFD);
    // a single EOT swallows whatever follows, even CAN
    send_word(1'b0, B_EOT);
    send_word(1'b0, B_SOH);
    send_word(1'b0, B_EOT);
    send_word(1'b0, B_CAN);
    send_word(1'b0, B_EOT);
    send_word(1'b0, 8'hFF);

    send_block(B_SOH, 8'd0, 1'b0);
    run_round(19, 62, 1'b0, 1'b0);

    set_capacity(offset_now + 24'($urandom_range(600, 100)));
    run_round(62, 19, 1'b1, 1'b0);

    set_capacity(24'hFFFFFF);
    run_round(0, 0, 1'b1, 1'b1);

    // shrink below the current offset, then close with zero capacity
    set_capacity(offset_now >> 1);
    set_capacity(24'd0);
    by_cancel = $urandom_range(1);
    if (by_cancel) begin
      send_word(1'b0, B_CAN);
    end else begin
      send_word(1'b0, B_EOT);
      send_word(1'b0, B_EOT);
    end
    // everything after the end of transfer is dropped
    send_word(1'b1, 8'h00);
    send_word(1'b0, B_SOH);
    send_word(1'b0, B_CAN);
    send_word(1'b0, 8'($urandom_range(255)));
    wait_idle();

    $display("Fed %0d words (%0d blocks plus short events), %0d capacity writes, three pacing mixes",
             words_sent, blocks_sent, cap_writes);
    $display("Checked %0d results; transfer closed by %s",
             checked_count, by_cancel ? "cancel" : "double EOT");
    if (pending_count != 0) $display("%0d predicted results never arrived", pending_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ycrc_pkg.sv
rtl/ycrc_front.sv
rtl/ycrc_queue.sv
rtl/ycrc_back.sv
rtl/ymodem_crc_receiver_core.sv
dv/ymodem_crc_checker.sv
dv/tb_ymodem_crc_receiver_core.sv
